FILE: sv/vctf_pkg.sv
// Shared types and constants for the vertex component to float converter.
`default_nettype none
package vctf_pkg;

  // Component formats held in the format register.
  typedef enum logic [2:0] {
    FMT_SBYTE  = 3'd0,
    FMT_UBYTE  = 3'd1,
    FMT_SSHORT = 3'd2,
    FMT_USHORT = 3'd3,
    FMT_UINT   = 3'd4,
    FMT_FLOAT  = 3'd5
  } vctf_fmt_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_FORMAT    = 3'd0;
  localparam logic [2:0] REG_NORMALIZE = 3'd1;
  localparam logic [2:0] REG_SRC_COMP  = 3'd2;
  localparam logic [2:0] REG_TGT_COMP  = 3'd3;
  localparam logic [2:0] REG_ABSENT    = 3'd4;

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_ZERO = 32'h0000_0000;

  // Biased exponent for a leading one at window bit 63 (integer path) and
  // for the repeating fraction pattern (normalized path).
  localparam logic [7:0] EXP_INT  = 8'd158;
  localparam logic [7:0] EXP_FRAC = 8'd126;

  typedef struct packed {
    vctf_fmt_t  fmt;
    logic       norm;
    logic [2:0] src_comp;
    logic [2:0] tgt_comp;
    logic       absent;
  } vctf_cfg_t;

  // One item in flight through the pipeline.
  typedef struct packed {
    logic        special;
    logic [31:0] special_bits;
    logic        sign;
    logic [7:0]  exp_base;
    logic        force_sticky;
    logic [63:0] win;
    logic [4:0]  lz;
    logic        last;
    logic        err;
  } vctf_item_t;

endpackage
`default_nettype wire

FILE: sv/vertex_component_to_float.sv
// Top level: vertex attribute component to IEEE single-precision converter.
// Throughput is one component per cycle; busy is always low, so start may
// stay high every cycle. The stages are decode, leading zero count, shift
// and round. Synchronous active-low reset clears the valid bits and loads
// the registers with format float, no normalize, four source and target
// components and a present source.
`default_nettype none
module vertex_component_to_float (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire [31:0]  in_raw_component,
  input  wire [1:0]   in_component_index,
  output logic        out_valid,
  output logic [31:0] out_value_bits,
  output logic        out_last_component,
  output logic        out_format_error,
  input  wire         cfg_we,
  input  wire [2:0]   cfg_index,
  input  wire [2:0]   cfg_wdata
);
  import vctf_pkg::*;

  vctf_cfg_t  cfg_r;
  logic       accept;
  logic       s1_vld, s3_vld;
  vctf_item_t s1_item, s3_item;

  // The pipeline never stalls, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Register writes land at once; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt      <= FMT_FLOAT;
      cfg_r.norm     <= 1'b0;
      cfg_r.src_comp <= 3'd4;
      cfg_r.tgt_comp <= 3'd4;
      cfg_r.absent   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT:    cfg_r.fmt      <= vctf_fmt_t'(cfg_wdata);
        REG_NORMALIZE: cfg_r.norm     <= cfg_wdata[0];
        REG_SRC_COMP:  cfg_r.src_comp <= cfg_wdata;
        REG_TGT_COMP:  cfg_r.tgt_comp <= cfg_wdata;
        REG_ABSENT:    cfg_r.absent   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Decode picks the constant results (padding, absent source, float
  // pass-through, errors) or sets up a window for the arithmetic path.
  vctf_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .raw      (in_raw_component),
    .idx      (in_component_index),
    .cfg      (cfg_r),
    .out_vld  (s1_vld),
    .out_item (s1_item)
  );

  vctf_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s1_vld),
    .in_item  (s1_item),
    .out_vld  (s3_vld),
    .out_item (s3_item)
  );

  // Output registers hold each result for exactly one strobe cycle.
  vctf_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s3_vld),
    .in_item  (s3_item),
    .out_vld  (out_valid),
    .out_bits (out_value_bits),
    .out_last (out_last_component),
    .out_err  (out_format_error)
  );

endmodule
`default_nettype wire

FILE: sv/vctf_decode.sv
// Stage one: format decode, padding rules and conversion window setup.
`default_nettype none
module vctf_decode (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_vld,
  input  wire [31:0]          raw,
  input  wire [1:0]           idx,
  input  vctf_pkg::vctf_cfg_t cfg,
  output logic                out_vld,
  output vctf_pkg::vctf_item_t out_item
);
  import vctf_pkg::*;

  typedef enum logic [2:0] {K_SPECIAL, K_INT, K_REP7, K_REP8, K_REP15, K_REP16} kind_t;

  vctf_item_t item_nxt, item_r;
  logic       vld_r;
  kind_t      kind;
  logic [31:0] imag;
  logic [7:0]  m8;
  logic [15:0] m16;
  logic        sgn;
  logic [7:0]  b8;
  logic [15:0] b16;

  always_comb begin
    b8   = raw[7:0];
    b16  = raw[15:0];
    kind = K_SPECIAL;
    imag = '0;
    m8   = '0;
    m16  = '0;
    sgn  = 1'b0;
    item_nxt = '0;
    item_nxt.special_bits = FP_ZERO;
    item_nxt.last = (cfg.tgt_comp != 3'd0) && ({1'b0, idx} == cfg.tgt_comp - 3'd1);

    if (cfg.absent) begin
      kind = K_SPECIAL;
    end else if ({1'b0, idx} < cfg.src_comp) begin
      case (cfg.fmt)
        FMT_SBYTE: begin
          sgn = b8[7];
          m8  = sgn ? 8'(-b8) : b8;
          if (cfg.norm) begin
            if (m8 == 8'd0) kind = K_SPECIAL;
            else if (m8 >= 8'd127) item_nxt.special_bits = {sgn, FP_ONE[30:0]};
            else kind = K_REP7;
          end else begin
            kind = K_INT;
            imag = {24'd0, m8};
          end
        end
        FMT_UBYTE: begin
          m8 = b8;
          if (cfg.norm) begin
            if (m8 == 8'd0) kind = K_SPECIAL;
            else if (m8 == 8'd255) item_nxt.special_bits = FP_ONE;
            else kind = K_REP8;
          end else begin
            kind = K_INT;
            imag = {24'd0, m8};
          end
        end
        FMT_SSHORT: begin
          sgn = b16[15];
          m16 = sgn ? 16'(-b16) : b16;
          if (cfg.norm) begin
            if (m16 == 16'd0) kind = K_SPECIAL;
            else if (m16 >= 16'd32767) item_nxt.special_bits = {sgn, FP_ONE[30:0]};
            else kind = K_REP15;
          end else begin
            kind = K_INT;
            imag = {16'd0, m16};
          end
        end
        FMT_USHORT: begin
          m16 = b16;
          if (cfg.norm) begin
            if (m16 == 16'd0) kind = K_SPECIAL;
            else if (m16 == 16'hFFFF) item_nxt.special_bits = FP_ONE;
            else kind = K_REP16;
          end else begin
            kind = K_INT;
            imag = {16'd0, m16};
          end
        end
        FMT_UINT: begin
          kind = K_INT;
          imag = raw;
        end
        FMT_FLOAT: begin
          item_nxt.special_bits = raw;
        end
        default: begin
          item_nxt.err = 1'b1;
        end
      endcase
    end else if (idx == 2'd3) begin
      item_nxt.special_bits = FP_ONE;
    end

    if (kind == K_INT && imag == 32'd0) kind = K_SPECIAL;

    item_nxt.sign = sgn;
    case (kind)
      K_INT: begin
        item_nxt.win      = {imag, 32'd0};
        item_nxt.exp_base = EXP_INT;
      end
      // Dividing by 2^n-1 gives the n-bit code repeated forever, so the
      // window holds the exact leading bits and the tail is never zero.
      K_REP7: begin
        item_nxt.win          = {{9{m8[6:0]}}, m8[6]};
        item_nxt.exp_base     = EXP_FRAC;
        item_nxt.force_sticky = 1'b1;
      end
      K_REP8: begin
        item_nxt.win          = {8{m8}};
        item_nxt.exp_base     = EXP_FRAC;
        item_nxt.force_sticky = 1'b1;
      end
      K_REP15: begin
        item_nxt.win          = {{4{m16[14:0]}}, m16[14:11]};
        item_nxt.exp_base     = EXP_FRAC;
        item_nxt.force_sticky = 1'b1;
      end
      K_REP16: begin
        item_nxt.win          = {4{m16}};
        item_nxt.exp_base     = EXP_FRAC;
        item_nxt.force_sticky = 1'b1;
      end
      default: begin
        item_nxt.special = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= in_vld;
    item_r <= item_nxt;
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule
`default_nettype wire

FILE: sv/vctf_norm.sv
// Stages two and three: leading zero count, then normalizing shift.
`default_nettype none
module vctf_norm (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_vld,
  input  vctf_pkg::vctf_item_t in_item,
  output logic                 out_vld,
  output vctf_pkg::vctf_item_t out_item
);
  import vctf_pkg::*;

  vctf_item_t cnt_nxt, cnt_r, sh_nxt, sh_r;
  logic       cnt_vld_r, sh_vld_r;

  // The leading one, if any, always sits in the upper half of the window.
  always_comb begin
    cnt_nxt    = in_item;
    cnt_nxt.lz = '0;
    for (int i = 0; i < 32; i++) begin
      if (in_item.win[i + 32]) cnt_nxt.lz = 5'(31 - i);
    end
  end

  always_comb begin
    sh_nxt     = cnt_r;
    sh_nxt.win = cnt_r.win << cnt_r.lz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= 1'b0;
      sh_vld_r  <= 1'b0;
    end else begin
      cnt_vld_r <= in_vld;
      sh_vld_r  <= cnt_vld_r;
    end
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
  end

  assign out_vld  = sh_vld_r;
  assign out_item = sh_r;

endmodule
`default_nettype wire

FILE: sv/vctf_round.sv
// Stage four: round to nearest even and pack the single-precision result.
`default_nettype none
module vctf_round (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_vld,
  input  vctf_pkg::vctf_item_t in_item,
  output logic                 out_vld,
  output logic [31:0]          out_bits,
  output logic                 out_last,
  output logic                 out_err
);
  import vctf_pkg::*;

  logic [22:0] mant;
  logic        rnd, sticky, up;
  logic [7:0]  expo;
  logic [30:0] mag;
  logic [31:0] bits_nxt, bits_r;
  logic        vld_r, last_r, err_r;

  always_comb begin
    mant   = in_item.win[62:40];
    rnd    = in_item.win[39];
    sticky = (|in_item.win[38:0]) | in_item.force_sticky;
    up     = rnd & (sticky | mant[0]);
    expo   = in_item.exp_base - {3'd0, in_item.lz};
    mag    = {expo, mant} + {30'd0, up};
    bits_nxt = in_item.special ? in_item.special_bits : {in_item.sign, mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= in_vld;
    bits_r <= bits_nxt;
    last_r <= in_item.last;
    err_r  <= in_item.err;
  end

  assign out_vld  = vld_r;
  assign out_bits = bits_r;
  assign out_last = last_r;
  assign out_err  = err_r;

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the vertex component to float converter.
`timescale 1ns / 1ps
module tb;
  import vctf_pkg::*;

  // One component presented to the converter, and one converted value.
  typedef struct {
    logic [31:0] raw;
    logic [1:0]  idx;
  } component_t;

  typedef struct {
    logic [31:0] value;
    logic        last;
    logic        err;
  } converted_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_raw_component = '0;
  logic [1:0]  in_component_index = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [2:0]  cfg_wdata = '0;
  wire         busy;
  wire         out_valid;
  wire  [31:0] out_value_bits;
  wire         out_last_component;
  wire         out_format_error;

  vertex_component_to_float dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_raw_component(in_raw_component),
    .in_component_index(in_component_index),
    .out_valid(out_valid),
    .out_value_bits(out_value_bits),
    .out_last_component(out_last_component),
    .out_format_error(out_format_error),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Our own copy of the configuration registers, updated as they are written.
  logic [2:0] cur_fmt = FMT_FLOAT;
  logic       cur_norm = 1'b0;
  logic [2:0] cur_src = 3'd4;
  logic [2:0] cur_tgt = 3'd4;
  logic       cur_absent = 1'b0;

  component_t pending_q[$];
  converted_t expected_q[$];
  int         idle_pct = 0;
  bit         hold_off = 1'b0;
  int         fail_count = 0;
  int         items_sent = 0;
  int         results_seen = 0;
  int         settings_used = 0;
  int         quiet_cycles = 0;

  // Rounds sign * mag / div to single precision, nearest even. The magnitude
  // is scaled by 2^48 first, so the quotient always holds more than 24
  // significant bits and the remainder only feeds the sticky decision.
  function automatic logic [31:0] round_quotient(logic sign, logic [31:0] mag,
                                                 logic [16:0] div);
    logic [79:0] scaled, quo, rem, low, half;
    logic [24:0] mant;
    int          msb, sh, expo;
    if (mag == 0) return FP_ZERO;
    scaled = {48'd0, mag} << 48;
    quo = scaled / div;
    rem = scaled % div;
    msb = 0;
    for (int i = 0; i < 80; i++) if (quo[i]) msb = i;
    sh = msb - 23;
    mant = 25'(quo >> sh);
    low = quo & ((80'd1 << sh) - 1);
    half = 80'd1 << (sh - 1);
    if (low > half || (low == half && (rem != 0 || mant[0]))) mant = mant + 1;
    expo = 127 + msb - 48;
    if (mant[24]) begin
      mant = mant >> 1;
      expo = expo + 1;
    end
    return {sign, 8'(expo), mant[22:0]};
  endfunction

  // Signed normalized results below -1.0 clamp to -1.0.
  function automatic logic [31:0] signed_component(logic [31:0] mag, logic neg,
                                                   logic [16:0] div);
    if (cur_norm && neg && mag > div) return {1'b1, FP_ONE[30:0]};
    return round_quotient(neg, mag, cur_norm ? div : 17'd1);
  endfunction

  function automatic converted_t convert_component(component_t c);
    converted_t r;
    logic [7:0]  b8;
    logic [15:0] b16;
    b8 = c.raw[7:0];
    b16 = c.raw[15:0];
    r.err = 1'b0;
    r.value = FP_ZERO;
    r.last = (cur_tgt != 0) && ({1'b0, c.idx} == cur_tgt - 3'd1);
    if (cur_absent) begin
      r.value = FP_ZERO;
    end else if ({1'b0, c.idx} < cur_src) begin
      case (cur_fmt)
        FMT_SBYTE: begin
          r.value = signed_component(b8[7] ? 32'(9'd256 - b8) : 32'(b8), b8[7], 17'd127);
        end
        FMT_UBYTE: r.value = round_quotient(1'b0, 32'(b8), cur_norm ? 17'd255 : 17'd1);
        FMT_SSHORT: begin
          r.value = signed_component(b16[15] ? 32'(17'd65536 - b16) : 32'(b16), b16[15],
                                     17'd32767);
        end
        FMT_USHORT: begin
          r.value = round_quotient(1'b0, 32'(b16), cur_norm ? 17'd65535 : 17'd1);
        end
        FMT_UINT: r.value = round_quotient(1'b0, c.raw, 17'd1);
        FMT_FLOAT: r.value = c.raw;
        default: r.err = 1'b1;
      endcase
    end else if (c.idx == 2'd3) begin
      r.value = FP_ONE;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
    fail_count++;
  endtask

  // Driver: issues the queued components, idling at the phase's rate. The
  // prediction is made at the edge where the transfer actually happens.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_q.insert(expected_q.size(),
                          convert_component('{in_raw_component, in_component_index}));
        items_sent++;
      end
      if (!start || !busy) begin
        if (pending_q.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          in_raw_component <= pending_q[0].raw;
          in_component_index <= pending_q[0].idx;
          pending_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", '0, out_value_bits);
      end else begin
        if (out_value_bits !== expected_q[0].value)
          report_mismatch("value_bits", expected_q[0].value, out_value_bits);
        if (out_last_component !== expected_q[0].last)
          report_mismatch("last_component", 32'(expected_q[0].last), 32'(out_last_component));
        if (out_format_error !== expected_q[0].err)
          report_mismatch("format_error", 32'(expected_q[0].err), 32'(out_format_error));
        expected_q.pop_front();
      end
    end
  end

  // Watchdog: a run that stops making transfers is declared hung.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Waits until nothing is queued, driven or still in the pipeline.
  task automatic drain();
    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [2:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FORMAT:    cur_fmt = val;
      REG_NORMALIZE: cur_norm = val[0];
      REG_SRC_COMP:  cur_src = val;
      REG_TGT_COMP:  cur_tgt = val;
      REG_ABSENT:    cur_absent = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [2:0] fmt, logic norm, logic [2:0] src,
                           logic [2:0] tgt, logic absent);
    drain();
    write_reg(REG_FORMAT, fmt);
    write_reg(REG_NORMALIZE, {2'b0, norm});
    write_reg(REG_SRC_COMP, src);
    write_reg(REG_TGT_COMP, tgt);
    write_reg(REG_ABSENT, {2'b0, absent});
    settings_used++;
  endtask

  task automatic queue_component(logic [31:0] raw, logic [1:0] idx);
    pending_q.insert(pending_q.size(), '{raw, idx});
  endtask

  // Random raw words lean toward the edges of each format, with random bits
  // above the part of the word the narrow formats look at.
  function automatic logic [31:0] pick_raw();
    logic [31:0] up;
    up = $urandom;
    case ($urandom_range(7))
      0: return {up[31:8], 8'h80};
      1: return {up[31:8], 8'h7F};
      2: return {up[31:16], 16'h8000};
      3: return {up[31:16], 16'hFFFF};
      4: return {up[31:24], 24'h000001};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // A few items at reset values: float passes through, index 3 is live.
    queue_component(32'h7FC0_0001, 2'd0);
    queue_component(32'hFFFF_FFFF, 2'd3);

    // Normalized signed byte: the most negative code clamps, the next does not.
    configure(FMT_SBYTE, 1'b1, 3'd4, 3'd4, 1'b0);
    queue_component(32'hFFFF_FF80, 2'd0);
    queue_component(32'h0000_0081, 2'd1);
    queue_component(32'hABCD_127F, 2'd2);
    queue_component(32'h0000_0000, 2'd3);
    configure(FMT_SSHORT, 1'b1, 3'd4, 3'd4, 1'b0);
    queue_component(32'h1234_8000, 2'd0);
    queue_component(32'h0000_7FFF, 2'd1);
    queue_component(32'h0000_FFFF, 2'd2);
    configure(FMT_USHORT, 1'b1, 3'd2, 3'd3, 1'b0);
    queue_component(32'hFFFF_FFFF, 2'd0);
    queue_component(32'h0000_0001, 2'd1);
    queue_component(32'h0000_0001, 2'd2);
    queue_component(32'h0000_0001, 2'd3);
    configure(FMT_UBYTE, 1'b1, 3'd1, 3'd1, 1'b0);
    queue_component(32'h0000_00FF, 2'd0);
    // Unsigned int ignores normalize; these exercise rounding ties.
    configure(FMT_UINT, 1'b1, 3'd7, 3'd0, 1'b0);
    queue_component(32'hFFFF_FFFF, 2'd0);
    queue_component(32'h0100_0001, 2'd1);
    queue_component(32'h0100_0003, 2'd3);
    // Unsupported formats, a zero source count and an absent source.
    configure(3'd6, 1'b0, 3'd4, 3'd4, 1'b0);
    queue_component(32'h1234_5678, 2'd0);
    configure(3'd7, 1'b0, 3'd0, 3'd4, 1'b0);
    queue_component(32'h1234_5678, 2'd3);
    queue_component(32'h1234_5678, 2'd1);
    configure(3'd7, 1'b1, 3'd4, 3'd2, 1'b1);
    queue_component(32'h1234_5678, 2'd1);
    queue_component(32'h1234_5678, 2'd3);

    // Random settings, each phase with the idle rate that its index selects.
    for (int ph = 0; ph < 38; ph++) begin
      configure(3'($urandom_range(7)), 1'($urandom_range(1)), 3'($urandom_range(7)),
                3'($urandom_range(7)), $urandom_range(7) == 0);
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 70;
        2: idle_pct = 0;
        default: idle_pct = 20;
      endcase
      n = 50;
      for (int i = 0; i < n; i++) queue_component(pick_raw(), 2'($urandom_range(3)));
      if (ph == 5) begin
        // Hold the sender until every result of the first half has arrived.
        while (pending_q.size() > 25) @(posedge clk);
        hold_off = 1'b1;
        while (start || expected_q.size() > 0) @(posedge clk);
        hold_off = 1'b0;
      end
    end

    drain();
    $display("Converted %0d components under %0d register settings, %0d results checked.",
             items_sent, settings_used, results_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
